// ===== design/gretd_pkg.sv =====
// Shared types and constants for the GRE tunnel encapsulation/decapsulation unit.
// Used by gretd_hdr_store and gre_tunnel_encap_decap_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package gretd_pkg;

  // Header store geometry: bytes held, packed four to a word.
  localparam int HDR_DEPTH     = 60;
  localparam int HDR_WORDS     = HDR_DEPTH / 4;
  localparam int HDR_AW        = $clog2(HDR_WORDS);

  localparam logic [13:0] MAX_LEN_RESET    = 14'd1514;
  localparam logic [14:0] TUNNEL_HDR_BYTES = 15'd24;
  localparam logic [15:0] LEN_ADD          = 16'd24;
  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  GRE_PROTO_NUM    = 8'd47;
  localparam logic [31:0] GRE_HDR_WORD     = 32'h0000_0800;

  // Frame byte positions.
  localparam logic [3:0] POS_TYPE_HI = 4'd12;
  localparam logic [3:0] POS_TYPE_LO = 4'd13;

  // Offsets inside the held IP header.
  localparam logic [5:0] IP_LEN_HI   = 6'd2;
  localparam logic [5:0] IP_LEN_LO   = 6'd3;
  localparam logic [5:0] IP_PROTO    = 6'd9;
  localparam logic [5:0] IP_CSUM_HI  = 6'd10;
  localparam logic [5:0] IP_CSUM_LO  = 6'd11;
  localparam logic [5:0] IP_MIN_HDR  = 6'd20;
  localparam logic [6:0] IMG_COPY    = 7'd24;

  // Offsets inside the inbound hold (index 0 is frame byte 13).
  localparam logic [5:0] DEC_PROTO    = 6'd10;
  localparam logic [5:0] DEC_FLAGS_HI = 6'd21;
  localparam logic [5:0] DEC_FLAGS_LO = 6'd22;
  localparam logic [5:0] DEC_STRIP    = 6'd24;

  // Status codes reported on the final result of a frame.
  localparam logic [2:0] ST_UNCHANGED = 3'd0;
  localparam logic [2:0] ST_ENCAP     = 3'd1;
  localparam logic [2:0] ST_DECAP     = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_NOT_GRE   = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  typedef enum logic [2:0] {
    M_DECIDE     = 3'd0,
    M_PASS       = 3'd1,
    M_TOO_LONG   = 3'd2,
    M_NOT_SIMPLE = 3'd3,
    M_ENC_HOLD   = 3'd4,
    M_ENC_STREAM = 3'd5,
    M_DEC_HOLD   = 3'd6,
    M_DEC_STREAM = 3'd7
  } frame_mode_t;

  typedef enum logic [1:0] {
    SQ_RUN  = 2'd0,
    SQ_READ = 2'd1,
    SQ_EMIT = 2'd2
  } seq_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        outbound;
    logic [13:0] frame_length;
  } in_req_t;

  typedef struct packed {
    logic [31:0] out_bytes;
    logic [2:0]  out_count;
    logic        out_last;
    logic [2:0]  out_status;
    logic        to_network;
  } out_res_t;

  // Byte write into the header store.
  typedef struct packed {
    logic              en;
    logic [HDR_AW-1:0] addr;
    logic [1:0]        lane;
    logic [7:0]        data;
  } hdr_wr_t;

endpackage
`default_nettype wire

// ===== design/gretd_hdr_store.sv =====
// Header store: word-wide synchronous memory with byte-lane writes.
// Depends on gretd_pkg for geometry and the write request type.
`timescale 1ns / 1ps
`default_nettype none
module gretd_hdr_store (
  input  wire logic                      clk,
  input  wire gretd_pkg::hdr_wr_t        wr,
  input  wire logic                      rd_en,
  input  wire logic [gretd_pkg::HDR_AW-1:0] rd_addr,
  output logic [31:0]                    rd_data
);

  logic [31:0] mem_r [gretd_pkg::HDR_WORDS];
  logic [31:0] rd_data_r;

  // Lane 0 is the first byte of the word, in bits 31..24.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      unique case (wr.lane)
        2'd0: mem_r[wr.addr][31:24] <= wr.data;
        2'd1: mem_r[wr.addr][23:16] <= wr.data;
        2'd2: mem_r[wr.addr][15:8]  <= wr.data;
        2'd3: mem_r[wr.addr][7:0]   <= wr.data;
        default: ;
      endcase
    end
  end

  // Registered read; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== design/gre_tunnel_encap_decap_unit.sv =====
// Top level of the GRE tunnel encapsulation/decapsulation unit.
// Depends on gretd_pkg and gretd_hdr_store.
//
//  Channel   Ports                               Direction  Carries
//  input     in_valid / in_ready / in_req        in         one frame byte per request
//  result    out_valid / out_ready / out_res     out        up to four bytes per request
//  config    cfg_wr_en / cfg_wr_data             in         max_frame_length, no wait
//
// A pass-through byte leaves through the output register. A header flush sends
// each word from the header store by a memory read, then an output load;
// encapsulation emits 11 to 21 words. No request is accepted during a flush.
// A stalled output holds its word and stops the flush. Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none
module gre_tunnel_encap_decap_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gretd_pkg::in_req_t in_req,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output gretd_pkg::out_res_t     out_res,
  input  wire logic               cfg_wr_en,
  input  wire logic [13:0]        cfg_wr_data
);

  // Frame state.
  gretd_pkg::frame_mode_t mode_r, mode_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  type_hi_r, type_hi_nxt;
  logic [5:0]  held_r, held_nxt;
  logic [5:0]  need_r, need_nxt;
  logic [5:0]  ihl4_r, ihl4_nxt;
  logic [21:0] csum_r, csum_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  byte13_r, byte13_nxt;
  logic        nz34_r, nz34_nxt;
  logic [13:0] max_len_r;

  // Flush sequencer.
  gretd_pkg::seq_t seq_r, seq_nxt;
  logic [4:0]  fl_k_r, fl_k_nxt;
  logic [4:0]  fl_words_r, fl_words_nxt;
  logic [5:0]  fl_bytes_r, fl_bytes_nxt;
  logic        fl_enc_r, fl_enc_nxt;
  logic        fl_last_r, fl_last_nxt;
  logic [2:0]  fl_status_r, fl_status_nxt;
  logic        fl_outb_r, fl_outb_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  gretd_pkg::out_res_t  out_r, out_nxt;

  // Memory interface.
  gretd_pkg::hdr_wr_t           mem_wr;
  logic                         mem_rd_en;
  logic [gretd_pkg::HDR_AW-1:0] mem_rd_addr;
  logic [31:0]                  mem_rd_data;

  logic        in_fire;
  logic        out_free;
  logic [15:0] ck;

  gretd_hdr_store u_hdr_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (seq_r == gretd_pkg::SQ_RUN) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Fold the running sum with end-around carry and complement it.
  always_comb begin
    logic [16:0] s1;
    logic [15:0] s2;
    s1 = {1'b0, csum_r[15:0]} + {11'b0, csum_r[21:16]};
    s2 = s1[15:0] + {15'b0, s1[16]};
    ck = ~s2;
  end

  // Request handling, hold bookkeeping and flush sequencing.
  always_comb begin
    logic [7:0]  b;
    logic        last;
    logic        emit;
    logic [7:0]  emit_byte;
    logic [2:0]  status;
    logic        start_fl;
    logic        fl_enc;
    logic [5:0]  fl_cnt;
    logic [5:0]  j;
    logic [5:0]  ihl_new;
    logic [5:0]  need_new;
    logic [5:0]  ihl_eff;
    logic [5:0]  need_eff;
    logic [15:0] shifted;
    logic [15:0] c1;
    logic [15:0] len_calc;
    logic        c1_en;
    logic        c2_en;
    logic [4:0]  raddr;
    logic        fin;
    logic [5:0]  rem;
    logic [2:0]  cnt;
    logic [31:0] word;

    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    type_hi_nxt   = type_hi_r;
    held_nxt      = held_r;
    need_nxt      = need_r;
    ihl4_nxt      = ihl4_r;
    csum_nxt      = csum_r;
    len_hi_nxt    = len_hi_r;
    len_nxt       = len_r;
    byte13_nxt    = byte13_r;
    nz34_nxt      = nz34_r;
    seq_nxt       = seq_r;
    fl_k_nxt      = fl_k_r;
    fl_words_nxt  = fl_words_r;
    fl_bytes_nxt  = fl_bytes_r;
    fl_enc_nxt    = fl_enc_r;
    fl_last_nxt   = fl_last_r;
    fl_status_nxt = fl_status_r;
    fl_outb_nxt   = fl_outb_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    mem_wr        = '0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;

    b         = in_req.data_byte;
    last      = in_req.last_byte;
    emit      = 1'b0;
    emit_byte = b;
    status    = gretd_pkg::ST_UNCHANGED;
    start_fl  = 1'b0;
    fl_enc    = 1'b0;
    fl_cnt    = '0;
    j         = held_r;
    ihl_new   = {b[3:0], 2'b00};
    need_new  = (ihl_new < gretd_pkg::IP_MIN_HDR) ? gretd_pkg::IP_MIN_HDR : ihl_new;
    ihl_eff   = (j == 6'd0) ? ihl_new : ihl4_r;
    need_eff  = (j == 6'd0) ? need_new : need_r;
    shifted   = j[0] ? {8'h00, b} : {b, 8'h00};
    len_calc  = {len_hi_r, b} + gretd_pkg::LEN_ADD;
    c1        = shifted;
    c1_en     = 1'b0;
    c2_en     = 1'b0;
    raddr     = '0;
    fin       = 1'b0;
    rem       = '0;
    cnt       = '0;
    word      = '0;

    if (in_fire) begin
      unique case (mode_r)
        gretd_pkg::M_DECIDE: begin
          if (pos_r < gretd_pkg::POS_TYPE_LO) begin
            if (pos_r == gretd_pkg::POS_TYPE_HI) begin
              type_hi_nxt = b;
            end
            emit   = 1'b1;
            status = gretd_pkg::ST_TRUNC;
          end else if ({type_hi_r, b} != gretd_pkg::ETHERTYPE_IPV4) begin
            emit     = 1'b1;
            mode_nxt = gretd_pkg::M_PASS;
            status   = gretd_pkg::ST_UNCHANGED;
          end else if (in_req.outbound) begin
            emit = 1'b1;
            if (({1'b0, in_req.frame_length} + gretd_pkg::TUNNEL_HDR_BYTES)
                <= {1'b0, max_len_r}) begin
              mode_nxt = gretd_pkg::M_ENC_HOLD;
              held_nxt = '0;
              need_nxt = '0;
              csum_nxt = '0;
              status   = gretd_pkg::ST_TRUNC;
            end else begin
              mode_nxt = gretd_pkg::M_TOO_LONG;
              status   = gretd_pkg::ST_TOO_LONG;
            end
          end else begin
            // Inbound IPv4: hold from the low ethertype byte on.
            mode_nxt     = gretd_pkg::M_DEC_HOLD;
            mem_wr.en    = 1'b1;
            mem_wr.addr  = '0;
            mem_wr.lane  = 2'd0;
            mem_wr.data  = b;
            byte13_nxt   = b;
            held_nxt     = 6'd1;
            nz34_nxt     = 1'b0;
            status       = gretd_pkg::ST_TRUNC;
            if (last) begin
              start_fl = 1'b1;
              fl_cnt   = 6'd1;
            end
          end
        end
        gretd_pkg::M_ENC_HOLD: begin
          if (j == 6'd0) begin
            ihl4_nxt = ihl_new;
            need_nxt = need_new;
          end
          if (j == gretd_pkg::IP_LEN_HI) begin
            len_hi_nxt = b;
          end
          if (j == gretd_pkg::IP_LEN_LO) begin
            len_nxt = len_calc;
          end
          mem_wr.en   = 1'b1;
          mem_wr.addr = j[gretd_pkg::HDR_AW+1:2];
          mem_wr.lane = j[1:0];
          mem_wr.data = b;
          held_nxt    = j + 6'd1;
          // Checksum image: modified header in the first 24 bytes, then a copy.
          priority if (j == gretd_pkg::IP_LEN_HI) begin
            c1 = '0;
          end else if (j == gretd_pkg::IP_LEN_LO) begin
            c1 = len_calc;
          end else if (j == gretd_pkg::IP_PROTO) begin
            c1 = {8'h00, gretd_pkg::GRE_PROTO_NUM};
          end else if (j == gretd_pkg::IP_CSUM_HI || j == gretd_pkg::IP_CSUM_LO) begin
            c1 = '0;
          end else begin
            c1 = shifted;
          end
          c1_en    = ({1'b0, j} < gretd_pkg::IMG_COPY) && (j < ihl_eff);
          c2_en    = ({1'b0, j} + gretd_pkg::IMG_COPY) < {1'b0, ihl_eff};
          csum_nxt = csum_r + (c1_en ? {6'b0, c1} : 22'd0)
                            + (c2_en ? {6'b0, shifted} : 22'd0);
          if ({1'b0, j} + 7'd1 >= {1'b0, need_eff}) begin
            start_fl = 1'b1;
            fl_enc   = 1'b1;
            fl_cnt   = need_eff;
            mode_nxt = gretd_pkg::M_ENC_STREAM;
            status   = gretd_pkg::ST_ENCAP;
          end else if (last) begin
            start_fl = 1'b1;
            fl_cnt   = j + 6'd1;
            status   = gretd_pkg::ST_TRUNC;
          end
        end
        gretd_pkg::M_DEC_HOLD: begin
          if (held_r >= gretd_pkg::DEC_STRIP) begin
            emit      = 1'b1;
            emit_byte = byte13_r;
            mode_nxt  = gretd_pkg::M_DEC_STREAM;
            status    = gretd_pkg::ST_DECAP;
          end else begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = j[gretd_pkg::HDR_AW+1:2];
            mem_wr.lane = j[1:0];
            mem_wr.data = b;
            held_nxt    = j + 6'd1;
            if (j == gretd_pkg::DEC_FLAGS_HI) begin
              nz34_nxt = (b != 8'h00);
            end
            if (j == gretd_pkg::DEC_PROTO && b != gretd_pkg::GRE_PROTO_NUM) begin
              start_fl = 1'b1;
              fl_cnt   = j + 6'd1;
              mode_nxt = gretd_pkg::M_PASS;
              status   = gretd_pkg::ST_UNCHANGED;
            end else if (j == gretd_pkg::DEC_FLAGS_LO && (nz34_r || b != 8'h00)) begin
              start_fl = 1'b1;
              fl_cnt   = j + 6'd1;
              mode_nxt = gretd_pkg::M_NOT_SIMPLE;
              status   = gretd_pkg::ST_NOT_GRE;
            end else if (last) begin
              start_fl = 1'b1;
              fl_cnt   = j + 6'd1;
              status   = gretd_pkg::ST_TRUNC;
            end
          end
        end
        gretd_pkg::M_TOO_LONG: begin
          emit   = 1'b1;
          status = gretd_pkg::ST_TOO_LONG;
        end
        gretd_pkg::M_NOT_SIMPLE: begin
          emit   = 1'b1;
          status = gretd_pkg::ST_NOT_GRE;
        end
        gretd_pkg::M_ENC_STREAM: begin
          emit   = 1'b1;
          status = gretd_pkg::ST_ENCAP;
        end
        gretd_pkg::M_DEC_STREAM: begin
          emit   = 1'b1;
          status = gretd_pkg::ST_DECAP;
        end
        default: begin
          emit   = 1'b1;
          status = gretd_pkg::ST_UNCHANGED;
        end
      endcase

      pos_nxt = (pos_r < gretd_pkg::POS_TYPE_LO) ? pos_r + 4'd1 : pos_r;
      if (last) begin
        pos_nxt  = '0;
        mode_nxt = gretd_pkg::M_DECIDE;
        held_nxt = '0;
        need_nxt = '0;
      end

      // Single byte straight to the output register.
      if (emit) begin
        out_valid_nxt      = 1'b1;
        out_nxt.out_bytes  = {emit_byte, 24'h000000};
        out_nxt.out_count  = 3'd1;
        out_nxt.out_last   = last;
        out_nxt.out_status = last ? status : gretd_pkg::ST_UNCHANGED;
        out_nxt.to_network = in_req.outbound;
      end

      // Capture the flush context.
      if (start_fl) begin
        seq_nxt       = gretd_pkg::SQ_READ;
        fl_k_nxt      = '0;
        fl_enc_nxt    = fl_enc;
        fl_bytes_nxt  = fl_cnt;
        fl_words_nxt  = fl_enc ? 5'd6 + {1'b0, fl_cnt[5:2]}
                               : 5'(({1'b0, fl_cnt} + 7'd3) >> 2);
        fl_last_nxt   = last;
        fl_status_nxt = status;
        fl_outb_nxt   = in_req.outbound;
      end
    end

    // Flush: read one stored word, then load it into the output register.
    unique case (seq_r)
      gretd_pkg::SQ_RUN: begin
      end
      gretd_pkg::SQ_READ: begin
        raddr       = (fl_enc_r && fl_k_r >= 5'd6) ? fl_k_r - 5'd6 : fl_k_r;
        mem_rd_en   = 1'b1;
        mem_rd_addr = raddr[gretd_pkg::HDR_AW-1:0];
        seq_nxt     = gretd_pkg::SQ_EMIT;
      end
      gretd_pkg::SQ_EMIT: begin
        if (out_free) begin
          fin = (fl_k_r == fl_words_r - 5'd1);
          if (fl_enc_r) begin
            cnt = 3'd4;
            priority if (fl_k_r == 5'd0) begin
              word = {mem_rd_data[31:16], len_r};
            end else if (fl_k_r == 5'd2) begin
              word = {mem_rd_data[31:24], gretd_pkg::GRE_PROTO_NUM, ck};
            end else if (fl_k_r == 5'd5) begin
              word = gretd_pkg::GRE_HDR_WORD;
            end else begin
              word = mem_rd_data;
            end
          end else begin
            rem  = fl_bytes_r - {fl_k_r[3:0], 2'b00};
            cnt  = (rem >= 6'd4) ? 3'd4 : rem[2:0];
            word = mem_rd_data;
            for (int l = 0; l < 4; l++) begin
              if (3'(l) >= cnt) begin
                word[31 - 8*l -: 8] = 8'h00;
              end
            end
          end
          out_valid_nxt      = 1'b1;
          out_nxt.out_bytes  = word;
          out_nxt.out_count  = cnt;
          out_nxt.out_last   = fl_last_r && fin;
          out_nxt.out_status = (fl_last_r && fin) ? fl_status_r : gretd_pkg::ST_UNCHANGED;
          out_nxt.to_network = fl_outb_r;
          if (fin) begin
            seq_nxt = gretd_pkg::SQ_RUN;
          end else begin
            fl_k_nxt = fl_k_r + 5'd1;
            seq_nxt  = gretd_pkg::SQ_READ;
          end
        end
      end
      default: seq_nxt = gretd_pkg::SQ_RUN;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= gretd_pkg::M_DECIDE;
      pos_r       <= '0;
      held_r      <= '0;
      need_r      <= '0;
      seq_r       <= gretd_pkg::SQ_RUN;
      out_valid_r <= 1'b0;
      max_len_r   <= gretd_pkg::MAX_LEN_RESET;
    end else begin
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      held_r      <= held_nxt;
      need_r      <= need_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    type_hi_r   <= type_hi_nxt;
    ihl4_r      <= ihl4_nxt;
    csum_r      <= csum_nxt;
    len_hi_r    <= len_hi_nxt;
    len_r       <= len_nxt;
    byte13_r    <= byte13_nxt;
    nz34_r      <= nz34_nxt;
    fl_k_r      <= fl_k_nxt;
    fl_words_r  <= fl_words_nxt;
    fl_bytes_r  <= fl_bytes_nxt;
    fl_enc_r    <= fl_enc_nxt;
    fl_last_r   <= fl_last_nxt;
    fl_status_r <= fl_status_nxt;
    fl_outb_r   <= fl_outb_nxt;
    out_r       <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== tb/gretd_checker.sv =====
// Scoreboard for the GRE tunnel encapsulation/decapsulation unit.
// Depends on gretd_pkg; watches both channels and the config port of the block.
`timescale 1ns / 1ps
module gretd_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  gretd_pkg::in_req_t  in_req,
  input  logic                out_valid,
  input  logic                out_ready,
  input  gretd_pkg::out_res_t out_res,
  input  logic                cfg_wr_en,
  input  logic [13:0]         cfg_wr_data,
  output int                  fail_count,
  output int                  pending
);
  import gretd_pkg::*;

  // Shadow copy of the frame state.
  logic [7:0]  hdr_mem [HDR_DEPTH];
  int          byte_pos;
  frame_mode_t mode;
  int          hdr_need;
  int          held;
  logic [7:0]  type_hi;
  logic [13:0] max_len;

  // Bytes produced by the current request, and the words still awaited.
  logic [7:0] tx_bytes [$];
  out_res_t   words_due [$];

  function automatic logic [7:0] hdr_rd(int i);
    return (i < HDR_DEPTH) ? hdr_mem[i] : 8'h00;
  endfunction

  function automatic logic [7:0] outer_byte(int i, logic [15:0] len);
    if (i == 2) return len[15:8];
    if (i == 3) return len[7:0];
    if (i == 9) return GRE_PROTO_NUM;
    if (i == 10 || i == 11) return 8'h00;
    if (i < 24) return hdr_rd(i);
    return hdr_rd(i - 24);
  endfunction

  task automatic hold_byte(logic [7:0] b);
    if (held < HDR_DEPTH) hdr_mem[held] = b;
    if (held < 63) held++;
  endtask

  task automatic flush_held();
    for (int i = 0; i < held; i++) tx_bytes.push_back(hdr_rd(i));
  endtask

  // Outer IP header with fresh checksum, GRE header, then the held header.
  task automatic emit_tunnel_header();
    int          ihl4;
    logic [15:0] len;
    logic [31:0] sum;
    logic [15:0] ck;
    ihl4 = hdr_rd(0) % 16 * 4;
    len  = {hdr_rd(2), hdr_rd(3)} + LEN_ADD;
    sum  = 0;
    for (int i = 0; i < ihl4; i += 2)
      sum += {outer_byte(i, len), outer_byte(i + 1, len)};
    while (sum[31:16] != 0) sum = sum[15:0] + sum[31:16];
    ck = ~sum[15:0];
    for (int i = 0; i < 20; i++) begin
      if (i == 10) tx_bytes.push_back(ck[15:8]);
      else if (i == 11) tx_bytes.push_back(ck[7:0]);
      else tx_bytes.push_back(outer_byte(i, len));
    end
    for (int i = 3; i >= 0; i--) tx_bytes.push_back(GRE_HDR_WORD[i*8 +: 8]);
    flush_held();
  endtask

  // Work out the results of one accepted request and queue them.
  task automatic predict_tunnel_bytes(in_req_t r);
    logic [7:0] b;
    logic [2:0] st;
    int         s, n;
    out_res_t   w;
    b  = r.data_byte;
    st = ST_UNCHANGED;
    tx_bytes.delete();
    case (mode)
      M_DECIDE: begin
        if (byte_pos < 13) begin
          if (byte_pos == 12) type_hi = b;
          tx_bytes.push_back(b);
          st = ST_TRUNC;
        end else if ({type_hi, b} != ETHERTYPE_IPV4) begin
          tx_bytes.push_back(b);
          mode = M_PASS;
        end else if (r.outbound) begin
          tx_bytes.push_back(b);
          if (int'(r.frame_length) + 24 <= int'(max_len)) begin
            mode = M_ENC_HOLD; held = 0; hdr_need = 0; st = ST_TRUNC;
          end else begin
            mode = M_TOO_LONG; st = ST_TOO_LONG;
          end
        end else begin
          mode = M_DEC_HOLD; held = 0; hold_byte(b); st = ST_TRUNC;
          if (r.last_byte) flush_held();
        end
      end
      M_ENC_HOLD: begin
        if (held == 0) begin
          hdr_need = b[3:0] * 4;
          if (hdr_need < 20) hdr_need = 20;
          if (hdr_need > HDR_DEPTH) hdr_need = HDR_DEPTH;
        end
        hold_byte(b);
        if (held >= hdr_need) begin
          emit_tunnel_header(); mode = M_ENC_STREAM; st = ST_ENCAP;
        end else if (r.last_byte) begin
          flush_held(); st = ST_TRUNC;
        end
      end
      M_DEC_HOLD: begin
        if (held >= 24) begin
          tx_bytes.push_back(hdr_rd(0)); mode = M_DEC_STREAM; st = ST_DECAP;
        end else begin
          s = held;
          hold_byte(b);
          if (s == 10 && b != GRE_PROTO_NUM) begin
            flush_held(); mode = M_PASS; st = ST_UNCHANGED;
          end else if (s == 22 && (hdr_rd(21) | hdr_rd(22)) != 0) begin
            flush_held(); mode = M_NOT_SIMPLE; st = ST_NOT_GRE;
          end else if (r.last_byte) begin
            flush_held(); st = ST_TRUNC;
          end
        end
      end
      default: begin
        tx_bytes.push_back(b);
        case (mode)
          M_TOO_LONG:   st = ST_TOO_LONG;
          M_NOT_SIMPLE: st = ST_NOT_GRE;
          M_ENC_STREAM: st = ST_ENCAP;
          M_DEC_STREAM: st = ST_DECAP;
          default:      st = ST_UNCHANGED;
        endcase
      end
    endcase

    if (byte_pos < 16383) byte_pos++;
    if (r.last_byte) begin
      byte_pos = 0; mode = M_DECIDE; held = 0; hdr_need = 0;
    end

    // Pack four bytes to a word, first byte in the top lane.
    n = (tx_bytes.size() + 3) / 4;
    for (int k = 0; k < n; k++) begin
      w = '0;
      for (int j = 0; j < 4; j++) begin
        if (k * 4 + j < tx_bytes.size()) begin
          w.out_bytes[31 - 8*j -: 8] = tx_bytes[k * 4 + j];
          w.out_count++;
        end
      end
      w.out_last   = r.last_byte && (k == n - 1);
      w.out_status = w.out_last ? st : ST_UNCHANGED;
      w.to_network = r.outbound;
      words_due.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (hdr_mem[i]) hdr_mem[i] = 8'h00;
      byte_pos = 0; mode = M_DECIDE; hdr_need = 0; held = 0; type_hi = 8'h00;
      max_len = MAX_LEN_RESET;
      words_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) max_len = cfg_wr_data;
      // Compare a delivered word against the oldest expectation.
      if (out_valid && out_ready) begin
        if (words_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_res);
        end else begin
          if (out_res !== words_due[0]) begin
            fail_count++;
            $display("%0t: result mismatch, expected %h, actual %h",
                     $time, words_due[0], out_res);
          end
          void'(words_due.pop_front());
        end
      end
      if (in_valid && in_ready) predict_tunnel_bytes(in_req);
    end
    pending = words_due.size();
  end
endmodule

// ===== tb/tb.sv =====
// Testbench top for the GRE tunnel encapsulation/decapsulation unit.
// Depends on gretd_pkg, the block and gretd_checker; builds frames and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import gretd_pkg::*;

  typedef enum int {FK_ENCAP, FK_DECAP, FK_OTHER_PROTO, FK_FLAGS, FK_OTHER_TYPE,
                    FK_CUT} frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_req_t     in_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_res_t    out_res;
  logic        cfg_wr_en = 1'b0;
  logic [13:0] cfg_wr_data = '0;
  int          fail_count, pending;
  int          sent_bytes = 0;
  bit          hold_req = 0;
  bit          steady = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  logic [7:0]  frame_q [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gre_tunnel_encap_decap_unit u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_req,
    .out_valid, .out_ready, .out_res, .cfg_wr_en, .cfg_wr_data
  );

  gretd_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_req, .out_valid, .out_ready, .out_res,
    .cfg_wr_en, .cfg_wr_data, .fail_count, .pending
  );

  // Result side: random stalls, mostly short, sometimes long, plus one long hold-off.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req   = 0;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (steady || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
    end
  end

  // Watchdog on cycles with no request or result moving.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 3000) begin
      $display("gre_tunnel_encap_decap_unit regression: fail");
      $finish;
    end
  end

  // Offer one byte request after an optional gap and wait until it is taken.
  task automatic send_byte(in_req_t r, int gap);
    bit taken;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    sent_bytes++;
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Build one frame of the given kind into frame_q.
  task automatic build_frame(frame_kind_t kind, int ihl, int extra);
    int hl;
    frame_q.delete();
    for (int i = 0; i < 12; i++) frame_q.push_back($urandom_range(0, 255));
    if (kind == FK_OTHER_TYPE) begin
      frame_q.push_back($urandom_range(0, 255));
      frame_q.push_back($urandom_range(0, 255));
    end else begin
      frame_q.push_back(8'h08);
      frame_q.push_back(8'h00);
    end
    hl = (ihl * 4 < 20) ? 20 : ihl * 4;
    frame_q.push_back({4'h4, ihl[3:0]});
    for (int i = 1; i < hl + extra; i++) frame_q.push_back($urandom_range(0, 255));
    if (kind != FK_ENCAP && kind != FK_OTHER_PROTO) frame_q[23] = GRE_PROTO_NUM;
    if (kind == FK_OTHER_PROTO && frame_q[23] == GRE_PROTO_NUM) frame_q[23] = 8'd6;
    if (kind == FK_DECAP && frame_q.size() > 35) begin
      frame_q[34] = 8'h00;
      frame_q[35] = 8'h00;
    end
    if (kind == FK_FLAGS && frame_q.size() > 35 && frame_q[34] == 0 && frame_q[35] == 0)
      frame_q[35] = 8'h80;
    if (kind == FK_CUT) frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 1)];
  endtask

  // Send frame_q; the length field is usually the true length.
  task automatic send_frame(bit outb, bit true_len);
    in_req_t r;
    logic [13:0] flen;
    flen = true_len ? 14'(frame_q.size()) : 14'($urandom_range(0, 16383));
    foreach (frame_q[i]) begin
      r.data_byte    = frame_q[i];
      r.last_byte    = (i == frame_q.size() - 1);
      r.outbound     = outb;
      r.frame_length = flen;
      send_byte(r, pick_gap());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_max_len(logic [13:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_frame();
    frame_kind_t kind;
    int          r, ihl;
    bit          outb;
    r = $urandom_range(0, 99);
    kind = (r < 35) ? FK_ENCAP : (r < 60) ? FK_DECAP : (r < 70) ? FK_OTHER_PROTO :
           (r < 78) ? FK_FLAGS : (r < 88) ? FK_OTHER_TYPE : FK_CUT;
    ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) :
          (kind == FK_ENCAP) ? $urandom_range(5, 15) : 5;
    build_frame(kind, ihl, $urandom_range(0, 12));
    outb = (kind == FK_ENCAP) ? 1'b1 : (kind == FK_CUT || kind == FK_OTHER_TYPE) ?
           1'($urandom_range(0, 1)) : 1'b0;
    send_frame(outb, $urandom_range(0, 9) != 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames, kept short: cut frames, encap, decap, other protocol, set flags.
    steady = 1;
    build_frame(FK_CUT, 5, 0); frame_q = frame_q[0:0]; send_frame(1'b0, 1'b1);
    build_frame(FK_CUT, 5, 0); frame_q = frame_q[0:13]; send_frame(1'b0, 1'b1);
    build_frame(FK_CUT, 5, 0); frame_q = frame_q[0:13]; send_frame(1'b1, 1'b1);
    // Encapsulation with options and a total length that wraps.
    build_frame(FK_ENCAP, 7, 0);
    frame_q[16] = 8'hFF; frame_q[17] = 8'hF0;
    send_frame(1'b1, 1'b1);
    build_frame(FK_DECAP, 5, 4); send_frame(1'b0, 1'b1);
    build_frame(FK_OTHER_PROTO, 5, 0); frame_q = frame_q[0:23]; send_frame(1'b0, 1'b1);
    build_frame(FK_FLAGS, 5, 2); send_frame(1'b0, 1'b1);
    steady = 0;

    // A frame too long for a small limit, sent while the result side holds off.
    write_max_len(14'd64);
    hold_req = 1;
    build_frame(FK_ENCAP, 5, 8); send_frame(1'b1, 1'b1);

    // One random frame under the largest limit.
    write_max_len(14'h3FFF);
    random_frame();

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("gre_tunnel_encap_decap_unit regression: pass");
    end else begin
      $display("gre_tunnel_encap_decap_unit regression: fail");
    end
    $finish;
  end
endmodule
